### hw/rtl/nptsv_pkg.sv
`default_nettype none

package nptsv_pkg;

    // Field widths and number formats
    localparam int MAG_W      = 15;
    localparam int ANG_W      = 16;
    localparam int CMP_W      = 16;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;

    // Sine table geometry: 256 segments over sixty degrees, Q30 entries
    localparam int IDX_W     = 8;
    localparam int ROM_SEGS  = 1 << IDX_W;
    localparam int SEG_SHIFT = ANGLE_BITS - IDX_W;
    localparam int ROM_W     = 31;
    localparam int Q_SHIFT   = 30;

    // Component and formula widths
    localparam int M_W = MAG_W + ROM_W - Q_SHIFT;
    localparam int F_W = M_W + 5;

    localparam logic [63:0] Q30_ONE       = 64'd1073741824;
    localparam logic [63:0] PI_OVER_3_Q30 = 64'd1124419809;
    localparam logic [63:0] TWO_RT3_Q30   = 64'd1239850262;

    // Compare formula codes
    typedef enum logic [3:0] {
        FM_Z, FM_O, FM_A, FM_B, FM_C, FM_D, FM_E,
        FM_F, FM_G, FM_H, FM_I, FM_J, FM_K
    } t_form;

    localparam int NFORM = 13;

    // Stage enables for the table lookup
    typedef struct packed {
        logic rd;
        logic ip;
    } t_lk_en;

    typedef logic [ROM_W-1:0] t_rom [ROM_SEGS];

    // (2/sqrt3)*sin(k*60deg/256) in Q30 by truncated Taylor series
    function automatic logic [63:0] f_rom_entry(input logic [63:0] k);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] a;
        begin
            t  = (PI_OVER_3_Q30 * k) / 64'd256;
            t2 = (t * t) >> Q_SHIFT;
            a  = Q30_ONE;
            a  = Q30_ONE - (((t2 * a) >> Q_SHIFT) / 64'd110);
            a  = Q30_ONE - (((t2 * a) >> Q_SHIFT) / 64'd72);
            a  = Q30_ONE - (((t2 * a) >> Q_SHIFT) / 64'd42);
            a  = Q30_ONE - (((t2 * a) >> Q_SHIFT) / 64'd20);
            a  = Q30_ONE - (((t2 * a) >> Q_SHIFT) / 64'd6);
            return (((t * a) >> Q_SHIFT) * TWO_RT3_Q30) >> Q_SHIFT;
        end
    endfunction

    // Segment start values, or with nxt set the segment end values
    function automatic t_rom f_rom(input logic nxt);
        t_rom        r;
        logic [63:0] e;
        begin
            for (int k = 0; k < ROM_SEGS; k++) begin
                e    = f_rom_entry(64'(k) + 64'(nxt));
                r[k] = e[ROM_W-1:0];
            end
            return r;
        end
    endfunction

    localparam t_rom ROM_LO = f_rom(1'b0);
    localparam t_rom ROM_HI = f_rom(1'b1);

    // [sector][subsector][cap_select][slot]
    localparam t_form FORM_TAB [6][4][2][6] = '{
        '{ '{ '{FM_A,FM_O,FM_O,FM_Z,FM_B,FM_O}, '{FM_Z,FM_O,FM_O,FM_Z,FM_C,FM_D} },
           '{ '{FM_A,FM_O,FM_O,FM_Z,FM_B,FM_O}, '{FM_Z,FM_E,FM_O,FM_Z,FM_Z,FM_D} },
           '{ '{FM_A,FM_F,FM_O,FM_Z,FM_Z,FM_O}, '{FM_Z,FM_E,FM_O,FM_Z,FM_Z,FM_D} },
           '{ '{FM_O,FM_O,FM_O,FM_J,FM_B,FM_O}, '{FM_J,FM_B,FM_O,FM_Z,FM_Z,FM_Z} } },
        '{ '{ '{FM_G,FM_A,FM_O,FM_Z,FM_Z,FM_O}, '{FM_I,FM_Z,FM_O,FM_Z,FM_Z,FM_D} },
           '{ '{FM_O,FM_A,FM_O,FM_H,FM_Z,FM_O}, '{FM_I,FM_Z,FM_O,FM_Z,FM_Z,FM_D} },
           '{ '{FM_O,FM_A,FM_O,FM_H,FM_Z,FM_O}, '{FM_O,FM_Z,FM_O,FM_K,FM_Z,FM_D} },
           '{ '{FM_O,FM_O,FM_O,FM_H,FM_J,FM_O}, '{FM_H,FM_J,FM_O,FM_Z,FM_Z,FM_Z} } },
        '{ '{ '{FM_O,FM_A,FM_O,FM_O,FM_Z,FM_B}, '{FM_O,FM_Z,FM_O,FM_D,FM_Z,FM_C} },
           '{ '{FM_O,FM_A,FM_O,FM_O,FM_Z,FM_B}, '{FM_O,FM_Z,FM_E,FM_D,FM_Z,FM_Z} },
           '{ '{FM_O,FM_A,FM_F,FM_O,FM_Z,FM_Z}, '{FM_O,FM_Z,FM_E,FM_D,FM_Z,FM_Z} },
           '{ '{FM_O,FM_O,FM_O,FM_O,FM_J,FM_B}, '{FM_O,FM_J,FM_B,FM_Z,FM_Z,FM_Z} } },
        '{ '{ '{FM_O,FM_G,FM_A,FM_O,FM_Z,FM_Z}, '{FM_O,FM_I,FM_Z,FM_D,FM_Z,FM_Z} },
           '{ '{FM_O,FM_O,FM_A,FM_O,FM_H,FM_Z}, '{FM_O,FM_I,FM_Z,FM_D,FM_Z,FM_Z} },
           '{ '{FM_O,FM_O,FM_A,FM_O,FM_H,FM_Z}, '{FM_O,FM_O,FM_Z,FM_D,FM_K,FM_Z} },
           '{ '{FM_O,FM_O,FM_O,FM_O,FM_H,FM_J}, '{FM_O,FM_H,FM_J,FM_Z,FM_Z,FM_Z} } },
        '{ '{ '{FM_O,FM_O,FM_A,FM_B,FM_O,FM_Z}, '{FM_O,FM_O,FM_Z,FM_C,FM_D,FM_Z} },
           '{ '{FM_O,FM_O,FM_A,FM_B,FM_O,FM_Z}, '{FM_E,FM_O,FM_Z,FM_Z,FM_D,FM_Z} },
           '{ '{FM_F,FM_O,FM_A,FM_Z,FM_O,FM_Z}, '{FM_E,FM_O,FM_Z,FM_Z,FM_D,FM_Z} },
           '{ '{FM_O,FM_O,FM_O,FM_B,FM_O,FM_J}, '{FM_B,FM_O,FM_J,FM_Z,FM_Z,FM_Z} } },
        '{ '{ '{FM_A,FM_O,FM_G,FM_Z,FM_O,FM_Z}, '{FM_Z,FM_O,FM_I,FM_Z,FM_D,FM_Z} },
           '{ '{FM_A,FM_O,FM_O,FM_Z,FM_O,FM_H}, '{FM_Z,FM_O,FM_I,FM_Z,FM_D,FM_Z} },
           '{ '{FM_A,FM_O,FM_O,FM_Z,FM_O,FM_H}, '{FM_Z,FM_O,FM_O,FM_Z,FM_D,FM_K} },
           '{ '{FM_O,FM_O,FM_O,FM_J,FM_O,FM_H}, '{FM_J,FM_O,FM_H,FM_Z,FM_Z,FM_Z} } }
    };

endpackage

`default_nettype wire

### hw/rtl/nptsv_lookup.sv
`default_nettype none

module nptsv_lookup (
    input  wire logic                           i_clk,
    input  wire nptsv_pkg::t_lk_en              i_en,
    input  wire logic [nptsv_pkg::ANGLE_BITS:0] i_u,
    output logic      [nptsv_pkg::ROM_W-1:0]    o_val
);
    import nptsv_pkg::*;

    logic                 w_full;
    logic [IDX_W-1:0]     w_idx;
    logic [ROM_W-1:0]     n_lo;
    logic [ROM_W-1:0]     n_hi;
    logic [SEG_SHIFT-1:0] n_frac;

    logic [ROM_W-1:0]     r_lo;
    logic [ROM_W-1:0]     r_hi;
    logic [SEG_SHIFT-1:0] r_frac;
    logic [ROM_W-1:0]     r_val;

    logic                       w_dec;
    logic [ROM_W-1:0]           w_diff;
    logic [ROM_W+SEG_SHIFT-1:0] w_prod;
    logic [ROM_W-1:0]           w_step;
    logic [ROM_W-1:0]           n_val;

    // Read segment ends; a full sixty degrees reads the last entry
    always_comb begin
        w_full = i_u[ANGLE_BITS];
        w_idx  = w_full ? {IDX_W{1'b1}} : i_u[ANGLE_BITS-1 -: IDX_W];
        n_hi   = ROM_HI[w_idx];
        n_lo   = w_full ? n_hi : ROM_LO[w_idx];
        n_frac = w_full ? '0 : i_u[SEG_SHIFT-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_frac <= n_frac;
        end
    end

    // Interpolate toward the segment end, truncating the step
    always_comb begin
        w_dec  = r_hi < r_lo;
        w_diff = w_dec ? (r_lo - r_hi) : (r_hi - r_lo);
        w_prod = {{SEG_SHIFT{1'b0}}, w_diff} * {{ROM_W{1'b0}}, r_frac};
        w_step = w_prod[SEG_SHIFT +: ROM_W];
        n_val  = w_dec ? (r_lo - w_step) : (r_lo + w_step);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ip) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

### hw/rtl/npc_three_level_svpwm_top.sv
`default_nettype none
// Each result passes all seven register stages, input register to output
// register. Throughput: one item per cycle unless the output stalls; the
// stages each have their own valid bit, and a stalled output holds its
// stage while bubbles ahead fill.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// The sine table is constant logic and needs no loading after reset.

module npc_three_level_svpwm_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [31:0]  i_s_tdata,   // magnitude[14:0], angle[30:15], zero
    input  wire logic         i_s_tuser,   // cap_select[0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic      [103:0] o_m_tdata    // sector[2:0], subsector[4:3],
                                           // compare_0..compare_5 16 bits each
                                           // from bit 5 up, zero[103:101]
);
    import nptsv_pkg::*;

    localparam int NSTG = 7;
    localparam logic [F_W-1:0] ONE  = F_W'(1) << FRAC_BITS;
    localparam logic [M_W:0]   HALF = (M_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [F_W-1:0] SAT_HI = F_W'(32767);
    localparam logic signed [F_W-1:0] SAT_LO = -F_W'(32768);

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    // Stage 1: input register
    logic [MAG_W-1:0]      r1_mag;
    logic [ANGLE_BITS-1:0] r1_ang;
    logic                  r1_cap;
    // Stage 2: sector and in-sector angle
    logic [MAG_W-1:0]      r2_mag;
    logic                  r2_cap;
    logic [2:0]            r2_sector;
    logic [ANGLE_BITS:0]   r2_u1;
    logic [ANGLE_BITS:0]   r2_u2;
    // Stages 3 and 4: side data beside the table lookup
    logic [MAG_W-1:0]      r3_mag;
    logic                  r3_cap;
    logic [2:0]            r3_sector;
    logic [MAG_W-1:0]      r4_mag;
    logic                  r4_cap;
    logic [2:0]            r4_sector;
    // Stage 5: components
    logic [M_W-1:0]        r5_m1;
    logic [M_W-1:0]        r5_m2;
    logic                  r5_cap;
    logic [2:0]            r5_sector;
    // Stage 6: subsector and formula values
    logic signed [F_W-1:0] r6_f [NFORM];
    logic [1:0]            r6_sub;
    logic                  r6_cap;
    logic [2:0]            r6_sector;
    // Stage 7: output register
    logic [CMP_W-1:0]      r7_cmp [6];
    logic [1:0]            r7_sub;
    logic [2:0]            r7_sector;

    // Each stage loads when empty or when the stage after it moves
    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: capture the transfer
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_mag <= i_s_tdata[MAG_W-1:0];
            r1_ang <= i_s_tdata[MAG_W +: ANGLE_BITS];
            r1_cap <= i_s_tuser;
        end
    end

    // Stage 2: angle*6 gives sector in the top bits, phase in the rest
    logic [ANGLE_BITS+2:0] w_p;
    logic [ANGLE_BITS:0]   w_phi;

    always_comb begin
        w_p   = ({3'b000, r1_ang} << 2) + ({3'b000, r1_ang} << 1);
        w_phi = {1'b0, w_p[ANGLE_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_mag    <= r1_mag;
            r2_cap    <= r1_cap;
            r2_sector <= w_p[ANGLE_BITS +: 3];
            r2_u2     <= w_phi;
            r2_u1     <= {1'b1, {ANGLE_BITS{1'b0}}} - w_phi;
        end
    end

    // Stages 3 and 4: table read and interpolation
    t_lk_en           w_lk_en;
    logic [ROM_W-1:0] w_lk1;
    logic [ROM_W-1:0] w_lk2;

    assign w_lk_en.rd = w_rdy[2];
    assign w_lk_en.ip = w_rdy[3];

    nptsv_lookup u_lk_m1 (
        .i_clk (i_clk),
        .i_en  (w_lk_en),
        .i_u   (r2_u1),
        .o_val (w_lk1)
    );

    nptsv_lookup u_lk_m2 (
        .i_clk (i_clk),
        .i_en  (w_lk_en),
        .i_u   (r2_u2),
        .o_val (w_lk2)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_mag    <= r2_mag;
            r3_cap    <= r2_cap;
            r3_sector <= r2_sector;
        end
        if (w_rdy[3]) begin
            r4_mag    <= r3_mag;
            r4_cap    <= r3_cap;
            r4_sector <= r3_sector;
        end
    end

    // Stage 5: scale by magnitude, drop the Q30 fraction
    logic [MAG_W+ROM_W-1:0] w_prod1;
    logic [MAG_W+ROM_W-1:0] w_prod2;

    always_comb begin
        w_prod1 = {{ROM_W{1'b0}}, r4_mag} * {{MAG_W{1'b0}}, w_lk1};
        w_prod2 = {{ROM_W{1'b0}}, r4_mag} * {{MAG_W{1'b0}}, w_lk2};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_m1     <= w_prod1[Q_SHIFT +: M_W];
            r5_m2     <= w_prod2[Q_SHIFT +: M_W];
            r5_cap    <= r4_cap;
            r5_sector <= r4_sector;
        end
    end

    // Stage 6: pick the triangle and evaluate every formula
    logic [M_W:0]          w_sum;
    logic [1:0]            n_sub;
    logic signed [F_W-1:0] w_m1;
    logic signed [F_W-1:0] w_m2;
    logic signed [F_W-1:0] w_one;
    logic signed [F_W-1:0] n_f [NFORM];

    always_comb begin
        w_sum = {1'b0, r5_m1} + {1'b0, r5_m2};
        if (w_sum < HALF) begin
            n_sub = 2'd3;
        end else if ({1'b0, r5_m1} >= HALF) begin
            n_sub = 2'd0;
        end else if ({1'b0, r5_m2} >= HALF) begin
            n_sub = 2'd2;
        end else begin
            n_sub = 2'd1;
        end
        w_m1  = signed'({{(F_W-M_W){1'b0}}, r5_m1});
        w_m2  = signed'({{(F_W-M_W){1'b0}}, r5_m2});
        w_one = signed'(ONE);
        n_f[FM_Z] = '0;
        n_f[FM_O] = w_one;
        n_f[FM_A] = (w_one - w_m1 - w_m2) <<< 1;
        n_f[FM_B] = w_one - (w_m2 <<< 1);
        n_f[FM_C] = (w_m1 <<< 1) - w_one;
        n_f[FM_D] = (w_m1 <<< 1) + (w_m2 <<< 1) - w_one;
        n_f[FM_E] = w_m1 <<< 1;
        n_f[FM_F] = (w_one - w_m2) <<< 1;
        n_f[FM_G] = (w_one - w_m1) <<< 1;
        n_f[FM_H] = w_one - (w_m1 <<< 1);
        n_f[FM_I] = w_m2 <<< 1;
        n_f[FM_J] = w_one - (w_m1 <<< 1) - (w_m2 <<< 1);
        n_f[FM_K] = (w_m2 <<< 1) - w_one;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_f      <= n_f;
            r6_sub    <= n_sub;
            r6_cap    <= r5_cap;
            r6_sector <= r5_sector;
        end
    end

    // Stage 7: select each slot's formula and saturate
    t_form                 w_code [6];
    logic signed [F_W-1:0] w_sel  [6];
    logic [CMP_W-1:0]      n_cmp  [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_code[j] = FORM_TAB[r6_sector][r6_sub][r6_cap][j];
            w_sel[j]  = r6_f[w_code[j]];
            if (w_sel[j] > SAT_HI) begin
                n_cmp[j] = SAT_HI[CMP_W-1:0];
            end else if (w_sel[j] < SAT_LO) begin
                n_cmp[j] = SAT_LO[CMP_W-1:0];
            end else begin
                n_cmp[j] = w_sel[j][CMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r7_cmp    <= n_cmp;
            r7_sub    <= r6_sub;
            r7_sector <= r6_sector;
        end
    end

    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = {3'b000, r7_cmp[5], r7_cmp[4], r7_cmp[3], r7_cmp[2],
                         r7_cmp[1], r7_cmp[0], r7_sub, r7_sector};

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'd5))
        else $error("sector out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline full and stalled");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[0])
        else $error("accepted transfer lost in first stage");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && w_rdy[6]) |=> o_m_tvalid)
        else $error("result lost entering output register");
`endif

endmodule

`default_nettype wire
